### src/mbd_pkg.sv
// ============================================================================
// mbd_pkg: shared types and constants of the mipmap box downsampler
// Texel, result, pair-sum and work-request types, the register index codes
// and the helper that forms per-channel pair sums.
// ============================================================================
package mbd_pkg;

    // Configuration register indexes and port widths.
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 13;
    localparam logic [CFG_INDEX_W-1:0] CFG_SOURCE_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SOURCE_HEIGHT = 2'd1;

    // Largest source height that the row counter covers.
    localparam logic [12:0] MAX_HEIGHT = 13'd4096;

    // One source texel.
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } t_texel;

    // One destination texel.
    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic [7:0] out_alpha;
        logic       level_done;
    } t_result;

    // Per-channel sum of a horizontal texel pair.
    typedef struct packed {
        logic [8:0] red;
        logic [8:0] green;
        logic [8:0] blue;
        logic [8:0] alpha;
    } t_pair;

    // What the back end does with a horizontal pair sum.
    typedef enum logic [1:0] {
        OP_STORE,
        OP_COMBINE,
        OP_DOUBLE
    } t_op;

    // One work request from the front end to the back end.
    typedef struct packed {
        t_op   op;
        t_pair hsum;
        logic  last;
    } t_work;

    // One configuration write request.
    typedef struct packed {
        logic                   valid;
        logic [CFG_INDEX_W-1:0] index;
        logic [CFG_DATA_W-1:0]  data;
    } t_cfg_req;

    // Adds two texels channel by channel into 9-bit sums.
    function automatic t_pair pair_add(input t_texel a, input t_texel b);
        t_pair s;
        s.red   = {1'b0, a.red}   + {1'b0, b.red};
        s.green = {1'b0, a.green} + {1'b0, b.green};
        s.blue  = {1'b0, a.blue}  + {1'b0, b.blue};
        s.alpha = {1'b0, a.alpha} + {1'b0, b.alpha};
        return s;
    endfunction

endpackage

### src/mbd_fifo.sv
// ============================================================================
// mbd_fifo: small register-based first-in first-out queue
// Holds up to DEPTH entries; the oldest entry is shown on o_data while
// o_empty is low. Push and pop may happen in the same cycle.
// ============================================================================
module mbd_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count,  n_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // Pointer and fill-count update with wrap at DEPTH.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

### src/mbd_front.sv
// ============================================================================
// mbd_front: texel position tracking and horizontal pairing
// Holds the source dimensions, follows the column and row of each incoming
// texel, forms horizontal pair sums and hands them to the back end as work
// requests that say whether to store, combine or double them.
// ============================================================================
module mbd_front #(
    parameter int MAX_WIDTH = 4096,
    parameter int SLOT_W    = 11
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  mbd_pkg::t_cfg_req    i_cfg,
    input  logic                 i_accept,
    input  mbd_pkg::t_texel      i_texel,
    output logic                 o_work_push,
    output mbd_pkg::t_work       o_work,
    output logic [SLOT_W-1:0]    o_slot
);

    localparam int CW    = $clog2(MAX_WIDTH + 1);
    localparam int CNT_W = $clog2(MAX_WIDTH);
    localparam int XW    = (CW > 13) ? CW : 13;
    localparam int DEPTH = MAX_WIDTH / 2;

    logic [12:0]       r_src_width;
    logic [12:0]       r_src_height;
    logic [CNT_W-1:0]  r_col, n_col;
    logic [11:0]       r_row, n_row;
    mbd_pkg::t_texel   r_left;

    logic [CW-1:0]     w_eff;
    logic [12:0]       h_eff;
    logic [CW-1:0]     col_next;
    logic [12:0]       row_next;
    logic              is_w1, is_h1, have_h, keep;
    logic [CW-1:0]     dx, dw_m1;
    logic [12:0]       dy, dh_m1;
    logic [CNT_W-1:0]  slot_x;
    mbd_pkg::t_op      op;

    // Effective dimensions: zero reads as one, oversize saturates.
    always_comb begin
        if (r_src_width == '0) begin
            w_eff = CW'(1);
        end else if (XW'(r_src_width) > XW'(MAX_WIDTH)) begin
            w_eff = CW'(MAX_WIDTH);
        end else begin
            w_eff = CW'(r_src_width);
        end
        if (r_src_height == '0) begin
            h_eff = 13'd1;
        end else if (r_src_height > mbd_pkg::MAX_HEIGHT) begin
            h_eff = mbd_pkg::MAX_HEIGHT;
        end else begin
            h_eff = r_src_height;
        end
    end

    assign is_w1    = (w_eff == CW'(1));
    assign is_h1    = (h_eff == 13'd1);
    assign col_next = CW'(r_col) + CW'(1);
    assign row_next = {1'b0, r_row} + 13'd1;
    assign have_h   = is_w1 || r_col[0];

    // Horizontal pair sum: a lone column counts twice.
    assign o_work.hsum = is_w1 ? mbd_pkg::pair_add(i_texel, i_texel)
                               : mbd_pkg::pair_add(r_left, i_texel);

    // Vertical role of the pair; an odd trailing row is dropped.
    always_comb begin
        op   = mbd_pkg::OP_COMBINE;
        keep = 1'b1;
        priority if (is_h1) begin
            op = mbd_pkg::OP_DOUBLE;
        end else if (!r_row[0]) begin
            op   = mbd_pkg::OP_STORE;
            keep = (row_next < h_eff);
        end else begin
            op = mbd_pkg::OP_COMBINE;
        end
    end

    assign o_work.op   = op;
    assign o_work_push = i_accept && have_h && keep;

    // Last destination texel of the level.
    assign dx    = is_w1 ? '0 : CW'(r_col >> 1);
    assign dw_m1 = is_w1 ? '0 : (w_eff >> 1) - CW'(1);
    assign dy    = is_h1 ? '0 : {2'b00, r_row[11:1]};
    assign dh_m1 = is_h1 ? '0 : (h_eff >> 1) - 13'd1;
    assign o_work.last = (dx == dw_m1) && (dy == dh_m1);

    // Line-store slot of this column pair, bounded by the store depth.
    assign slot_x = r_col >> 1;
    assign o_slot = (CW'(slot_x) >= CW'(DEPTH)) ? SLOT_W'(DEPTH - 1) : SLOT_W'(slot_x);

    // Position advance in row-major order.
    always_comb begin
        if (col_next >= w_eff) begin
            n_col = '0;
            n_row = (row_next >= h_eff) ? '0 : row_next[11:0];
        end else begin
            n_col = col_next[CNT_W-1:0];
            n_row = r_row;
        end
    end

    // Registers and position counters; a write to the width or height register restarts the pass.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_width  <= 13'd1;
            r_src_height <= 13'd1;
            r_col        <= '0;
            r_row        <= '0;
        end else if (i_cfg.valid) begin
            if (i_cfg.index == mbd_pkg::CFG_SOURCE_WIDTH) begin
                r_src_width <= i_cfg.data;
                r_col       <= '0;
                r_row       <= '0;
            end else if (i_cfg.index == mbd_pkg::CFG_SOURCE_HEIGHT) begin
                r_src_height <= i_cfg.data;
                r_col        <= '0;
                r_row        <= '0;
            end
        end else if (i_accept) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // Left texel of the pending pair.
    always_ff @(posedge i_clk) begin
        if (i_accept && !r_col[0]) begin
            r_left <= i_texel;
        end
    end

endmodule

### src/mbd_back.sv
// ============================================================================
// mbd_back: line store and vertical combination
// Takes work requests, writes even-row pair sums into the line store, reads
// them back for the odd row, adds the two rows (or doubles a lone row) and divides by four.
// ============================================================================
module mbd_back #(
    parameter int MAX_WIDTH = 4096,
    parameter int SLOT_W    = 11
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_work_empty,
    output logic                 o_work_pop,
    input  mbd_pkg::t_work       i_work,
    input  logic [SLOT_W-1:0]    i_slot,
    input  logic                 i_res_full,
    output logic                 o_res_push,
    output mbd_pkg::t_result     o_result
);

    localparam int DEPTH = (MAX_WIDTH / 2 > 0) ? MAX_WIDTH / 2 : 1;

    mbd_pkg::t_pair   r_store [DEPTH];
    mbd_pkg::t_pair   r_rd_data;
    logic             r_s1_valid;
    mbd_pkg::t_work   r_s1_work;
    logic             advance;
    logic [9:0]       t_red, t_green, t_blue, t_alpha;

    // The result stage drains when it is empty or the result queue has room.
    assign advance    = !r_s1_valid || !i_res_full;
    assign o_work_pop = !i_work_empty && advance;
    assign o_res_push = r_s1_valid && !i_res_full;

    // Result stage valid flag; store requests finish at the memory write.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (advance) begin
            r_s1_valid <= o_work_pop && (i_work.op != mbd_pkg::OP_STORE);
        end
    end

    // Line store: one write and one registered read per cycle, while a work request is popped.
    always_ff @(posedge i_clk) begin
        if (o_work_pop && (i_work.op == mbd_pkg::OP_STORE)) begin
            r_store[i_slot] <= i_work.hsum;
        end
        if (o_work_pop) begin
            r_rd_data <= r_store[i_slot];
            r_s1_work <= i_work;
        end
    end

    // Two-row sum: stored row plus current row, or the single row doubled.
    always_comb begin
        unique case (r_s1_work.op)
            mbd_pkg::OP_COMBINE: begin
                t_red   = {1'b0, r_rd_data.red}   + {1'b0, r_s1_work.hsum.red};
                t_green = {1'b0, r_rd_data.green} + {1'b0, r_s1_work.hsum.green};
                t_blue  = {1'b0, r_rd_data.blue}  + {1'b0, r_s1_work.hsum.blue};
                t_alpha = {1'b0, r_rd_data.alpha} + {1'b0, r_s1_work.hsum.alpha};
            end
            default: begin
                t_red   = {r_s1_work.hsum.red,   1'b0};
                t_green = {r_s1_work.hsum.green, 1'b0};
                t_blue  = {r_s1_work.hsum.blue,  1'b0};
                t_alpha = {r_s1_work.hsum.alpha, 1'b0};
            end
        endcase
    end

    // Divide by four.
    assign o_result.out_red    = t_red[9:2];
    assign o_result.out_green  = t_green[9:2];
    assign o_result.out_blue   = t_blue[9:2];
    assign o_result.out_alpha  = t_alpha[9:2];
    assign o_result.level_done = r_s1_work.last;

endmodule

### src/mipmap_box_downsample_unit.sv
// ============================================================================
// mipmap_box_downsample_unit: 2x2 box-filter mipmap level downsampler
// Streams the RGBA texels of one source level in row-major order and
// returns the texels of the next smaller level, one pass per level.
// ============================================================================
//
//  channel   | direction | handshake                   | payload
//  ----------+-----------+-----------------------------+------------------------
//  texels    | in        | push, full (accept: push&!full) | i_texel (t_texel)
//  results   | out       | empty, pop (accept: pop&!empty) | o_result (t_result)
//  config    | in        | i_cfg_valid, o_cfg_ready    | i_cfg_index, i_cfg_data
//
//  One texel is accepted every cycle while full is low; the front end forms each column
//  pair in the cycle that its right texel is accepted. The pair sum that completes a 2x2
//  block passes through the work queue, the registered line-store read, the add and the result queue.
//  The line store has one write and one read port; reads serve every texel pair, writes only even-row pairs.
//  Reset clears counters and queues; the line store is not cleared,
//  since each entry is written in an even row before the odd row reads it.
//  A full result queue stalls the back end; the work queue then fills and raises
//  full. Configuration writes are always ready; width and height writes restart the pass.
//
module mipmap_box_downsample_unit #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                push,
    output logic                                full,
    input  mbd_pkg::t_texel                     i_texel,
    output logic                                empty,
    input  logic                                pop,
    output mbd_pkg::t_result                    o_result,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [mbd_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  logic [mbd_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    localparam int DEPTH   = (MAX_WIDTH / 2 > 0) ? MAX_WIDTH / 2 : 1;
    localparam int SLOT_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int WORK_W  = SLOT_W + $bits(mbd_pkg::t_work);
    localparam int RES_W   = $bits(mbd_pkg::t_result);

    mbd_pkg::t_cfg_req   cfg_req;
    logic                accept;
    logic                work_push, work_full, work_empty, work_pop;
    mbd_pkg::t_work      work_in, work_out;
    logic [SLOT_W-1:0]   slot_in, slot_out;
    logic [WORK_W-1:0]   work_q_out;
    logic                res_push, res_full;
    mbd_pkg::t_result    res_in;
    logic [RES_W-1:0]    res_q_out;

    // Configuration writes are taken in any cycle.
    assign o_cfg_ready   = 1'b1;
    assign cfg_req.valid = i_cfg_valid;
    assign cfg_req.index = i_cfg_index;
    assign cfg_req.data  = i_cfg_data;

    assign full   = work_full;
    assign accept = push && !work_full;

    // Front end: position tracking and horizontal pairing.
    mbd_front #(
        .MAX_WIDTH (MAX_WIDTH),
        .SLOT_W    (SLOT_W)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg_req),
        .i_accept    (accept),
        .i_texel     (i_texel),
        .o_work_push (work_push),
        .o_work      (work_in),
        .o_slot      (slot_in)
    );

    // Work queue between front and back.
    mbd_fifo #(
        .WIDTH (WORK_W),
        .DEPTH (4)
    ) u_work_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (work_push),
        .i_data  ({slot_in, work_in}),
        .o_full  (work_full),
        .i_pop   (work_pop),
        .o_data  (work_q_out),
        .o_empty (work_empty)
    );

    assign slot_out = work_q_out[WORK_W-1 -: SLOT_W];
    assign work_out = mbd_pkg::t_work'(work_q_out[$bits(mbd_pkg::t_work)-1:0]);

    // Back end: line store and vertical combination.
    mbd_back #(
        .MAX_WIDTH (MAX_WIDTH),
        .SLOT_W    (SLOT_W)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_work_empty (work_empty),
        .o_work_pop   (work_pop),
        .i_work       (work_out),
        .i_slot       (slot_out),
        .i_res_full   (res_full),
        .o_res_push   (res_push),
        .o_result     (res_in)
    );

    // Result queue facing the consumer.
    mbd_fifo #(
        .WIDTH (RES_W),
        .DEPTH (4)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_in),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (res_q_out),
        .o_empty (empty)
    );

    assign o_result = mbd_pkg::t_result'(res_q_out);

endmodule

### src/mbd_checker.sv
// ============================================================================
// mbd_checker: port-level checks of the mipmap box downsampler
// Watches the top-level ports for reset behavior, result latency and
// result stability while the consumer stalls.
// ============================================================================
module mbd_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             push,
    input logic             full,
    input logic             empty,
    input logic             pop,
    input mbd_pkg::t_result o_result
);

    // Reset leaves no result waiting.
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result shown right after reset");

    // Reset leaves room for input.
    a_reset_not_full: assert property (@(posedge i_clk) !i_rst_n |=> !full)
        else $error("input side full right after reset");

    // Out of reset, with no texel pushed, no result is shown.
    a_min_latency: assert property (@(posedge i_clk)
        !i_rst_n ##1 !push |=> empty)
        else $error("result appeared without enough latency after reset");

    // A waiting result holds while it is not popped.
    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_result))
        else $error("waiting result changed or vanished");

endmodule

bind mipmap_box_downsample_unit mbd_checker u_mbd_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .push     (push),
    .full     (full),
    .empty    (empty),
    .pop      (pop),
    .o_result (o_result)
);

### verif/mipmap_box_downsample_unit_tb.sv
// ============================================================================
// mipmap_box_downsample_unit_tb: self-checking bench for the 2x2 downsampler
// Streams source texels through the push/full side under random pacing,
// predicts every destination texel from an internal model of the filter and
// compares each popped result field by field. Covers 1x1, odd and oversized
// level sizes, ignored register writes and restarts mid-pass.
// ============================================================================
module mipmap_box_downsample_unit_tb;
    import mbd_pkg::*;

    localparam int LINE_SLOTS     = 2048;
    localparam int DIM_LIMIT      = 4096;
    localparam int RANDOM_TEXELS  = 1240;
    localparam int LARGE_TEXELS   = 64;
    localparam int SETTLE_CYCLES  = 8;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_HI = 2'd3;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   push = 1'b0;
    logic                   full;
    t_texel                 i_texel = '0;
    logic                   empty;
    logic                   pop = 1'b0;
    t_result                o_result;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_INDEX_W-1:0] i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;

    // Model of the downsampler: registers, scan position and the stores.
    logic [CFG_DATA_W-1:0]  model_width = 13'd1;
    logic [CFG_DATA_W-1:0]  model_height = 13'd1;
    int unsigned            model_col = 0;
    int unsigned            model_row = 0;
    logic [7:0]             left_texel [4];
    logic [8:0]             line_store [LINE_SLOTS][4];

    t_texel                 source_texels [$];
    t_result                expected_texels [$];

    int unsigned            texel_gap_max = 0;
    int unsigned            result_stall_max = 0;
    int unsigned            texel_gap = 0;
    int unsigned            result_stall = 0;
    int unsigned            stall_draw;
    int unsigned            mismatch_count = 0;
    int unsigned            results_seen = 0;

    mipmap_box_downsample_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_texel     (i_texel),
        .empty       (empty),
        .pop         (pop),
        .o_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // A register value of zero means one; larger values saturate.
    function automatic int unsigned eff_dim(input logic [CFG_DATA_W-1:0] v);
        if (v == 0) return 1;
        if (v > DIM_LIMIT) return DIM_LIMIT;
        return v;
    endfunction

    // Folds one accepted source texel into the model and queues the
    // destination texel it completes, if any.
    task automatic fold_texel(input t_texel tx);
        int unsigned w, h, slot, dw, dh, dx, dy;
        logic [7:0]  chan [4];
        logic [8:0]  hsum [4];
        logic [9:0]  total [4];
        bit          have_pair, emit;
        t_result     res;
        w = eff_dim(model_width);
        h = eff_dim(model_height);
        chan[0] = tx.red;
        chan[1] = tx.green;
        chan[2] = tx.blue;
        chan[3] = tx.alpha;
        have_pair = 1'b0;
        emit = 1'b0;

        // Horizontal pairing; a lone column pairs with itself.
        if (w == 1) begin
            foreach (chan[k]) hsum[k] = {chan[k], 1'b0};
            have_pair = 1'b1;
        end else if (model_col[0] == 1'b0) begin
            if (model_col + 1 < w) begin
                foreach (chan[k]) left_texel[k] = chan[k];
            end
        end else begin
            foreach (chan[k]) hsum[k] = {1'b0, left_texel[k]} + {1'b0, chan[k]};
            have_pair = 1'b1;
        end

        // Vertical pairing through the line store; a lone row doubles.
        if (have_pair) begin
            slot = (w == 1) ? 0 : model_col >> 1;
            if (h == 1) begin
                foreach (hsum[k]) total[k] = {hsum[k], 1'b0};
                emit = 1'b1;
            end else if (model_row[0] == 1'b0) begin
                if (model_row + 1 < h) begin
                    foreach (hsum[k]) line_store[slot][k] = hsum[k];
                end
            end else begin
                foreach (hsum[k]) total[k] = {1'b0, line_store[slot][k]} + {1'b0, hsum[k]};
                emit = 1'b1;
            end
        end

        if (emit) begin
            dw = (w / 2 > 0) ? w / 2 : 1;
            dh = (h / 2 > 0) ? h / 2 : 1;
            dx = (w == 1) ? 0 : model_col >> 1;
            dy = (h == 1) ? 0 : model_row >> 1;
            res.out_red    = total[0][9:2];
            res.out_green  = total[1][9:2];
            res.out_blue   = total[2][9:2];
            res.out_alpha  = total[3][9:2];
            res.level_done = (dx == dw - 1) && (dy == dh - 1);
            expected_texels.push_back(res);
        end

        // Step the scan position, wrapping at the end of the level.
        if (model_col + 1 >= w) begin
            model_col = 0;
            model_row = (model_row + 1 >= h) ? 0 : model_row + 1;
        end else begin
            model_col = model_col + 1;
        end
    endtask

    task automatic report_mismatch(input string field, input logic [7:0] want,
                                   input logic [7:0] got);
        mismatch_count++;
        $display("MISMATCH result %0d %s: expected %0h, got %0h",
                 results_seen, field, want, got);
    endtask

    task automatic check_result(input t_result got);
        t_result want;
        if (expected_texels.size() == 0) begin
            report_mismatch("unexpected result, out_red", 8'h00, got.out_red);
            return;
        end
        want = expected_texels.pop_front();
        if (got.out_red !== want.out_red)
            report_mismatch("out_red", want.out_red, got.out_red);
        if (got.out_green !== want.out_green)
            report_mismatch("out_green", want.out_green, got.out_green);
        if (got.out_blue !== want.out_blue)
            report_mismatch("out_blue", want.out_blue, got.out_blue);
        if (got.out_alpha !== want.out_alpha)
            report_mismatch("out_alpha", want.out_alpha, got.out_alpha);
        if (got.level_done !== want.level_done)
            report_mismatch("level_done", {7'b0, want.level_done},
                            {7'b0, got.level_done});
    endtask

    // Texel driver: presents queued requests with a random gap before each.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
            texel_gap <= 0;
        end else begin
            if (push && !full) fold_texel(i_texel);
            if (!push || !full) begin
                if (texel_gap != 0) begin
                    push <= 1'b0;
                    texel_gap <= texel_gap - 1;
                end else if (source_texels.size() != 0) begin
                    i_texel <= source_texels.pop_front();
                    push <= 1'b1;
                    texel_gap <= $urandom_range(0, texel_gap_max);
                end else begin
                    push <= 1'b0;
                end
            end
        end
    end

    // Result monitor: checks each popped request, then stalls at random.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
            result_stall <= 0;
        end else if (pop && !empty) begin
            check_result(o_result);
            results_seen++;
            stall_draw = $urandom_range(0, result_stall_max);
            pop <= (stall_draw == 0);
            result_stall <= stall_draw;
        end else if (result_stall != 0) begin
            pop <= (result_stall == 1);
            result_stall <= result_stall - 1;
        end else begin
            pop <= 1'b1;
        end
    end

    // Waits until every texel is in and every predicted result is out,
    // then lets the pipeline settle for texels that produce nothing.
    task automatic wait_quiet();
        while (source_texels.size() != 0 || push || expected_texels.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Writes one register while the block is quiet and mirrors it in the model.
    task automatic configure(input logic [CFG_INDEX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] data);
        wait_quiet();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (index == CFG_SOURCE_WIDTH || index == CFG_SOURCE_HEIGHT) begin
            if (index == CFG_SOURCE_WIDTH) model_width = data;
            else model_height = data;
            model_col = 0;
            model_row = 0;
        end
        i_cfg_valid <= 1'b0;
    endtask

    // Channel values lean toward the extremes now and then.
    function automatic logic [7:0] pick_channel();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_texels(input int unsigned count);
        repeat (count) begin
            source_texels.push_back({pick_channel(), pick_channel(),
                                     pick_channel(), pick_channel()});
        end
    endtask

    // Picks new pacing for both sides; each side gets no idling at all a third of the time.
    task automatic set_pace();
        texel_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 4;
        result_stall_max = ($urandom_range(0, 2) == 0) ? 0 : 4;
    endtask

    function automatic logic [CFG_DATA_W-1:0] pick_dim();
        case ($urandom_range(0, 9))
            0: return 13'd0;
            1: return CFG_DATA_W'($urandom_range(17, 40));
            default: return CFG_DATA_W'($urandom_range(1, 8));
        endcase
    endfunction

    initial begin : stimulus
        int unsigned sent, count;
        logic [CFG_DATA_W-1:0] w, h;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        set_pace();

        // Reset size is 1x1: each texel is its own destination texel.
        // Channel order in the literals: red, green, blue, alpha.
        source_texels.push_back({8'hFF, 8'hFF, 8'hFF, 8'hFF});
        source_texels.push_back({8'h00, 8'h00, 8'h00, 8'h00});

        // A 2x2 block whose green, blue and alpha sums do not divide evenly by four.
        configure(CFG_SOURCE_WIDTH, 13'd2);
        configure(CFG_SOURCE_HEIGHT, 13'd2);
        source_texels.push_back({8'hFF, 8'h00, 8'h01, 8'h80});
        source_texels.push_back({8'hFF, 8'h00, 8'h02, 8'h7F});
        source_texels.push_back({8'hFF, 8'h00, 8'h00, 8'h01});
        source_texels.push_back({8'hFF, 8'h01, 8'hFF, 8'hFE});

        // Odd trailing column and row are dropped.
        configure(CFG_SOURCE_WIDTH, 13'd3);
        configure(CFG_SOURCE_HEIGHT, 13'd3);
        send_texels(9);

        // Width written as zero acts as one column; the odd row is dropped.
        configure(CFG_SOURCE_WIDTH, 13'd0);
        send_texels(3);

        // A single row doubles each pair sum.
        configure(CFG_SOURCE_HEIGHT, 13'd1);
        configure(CFG_SOURCE_WIDTH, 13'd4);
        send_texels(4);

        // A write to an unused index must not disturb the pass in flight.
        configure(CFG_SOURCE_HEIGHT, 13'd2);
        send_texels(3);
        configure(CFG_SPARE_LO, 13'h1FFF);
        send_texels(1);
        // A real write restarts the pass at the top-left texel.
        configure(CFG_SOURCE_HEIGHT, 13'd2);
        send_texels(8);

        // Oversized register values: the start of a very wide and a very
        // tall level, each cut short by the next write.
        set_pace();
        configure(CFG_SOURCE_WIDTH, 13'h1FFF);
        configure(CFG_SOURCE_HEIGHT, 13'd0);
        send_texels(LARGE_TEXELS);
        set_pace();
        configure(CFG_SOURCE_WIDTH, 13'd0);
        configure(CFG_SOURCE_HEIGHT, 13'h1FFF);
        send_texels(LARGE_TEXELS);

        // Back to a small level before the random mix.
        configure(CFG_SOURCE_HEIGHT, 13'd2);

        // Random levels, mostly complete passes, some cut short by a write.
        sent = 0;
        while (sent < RANDOM_TEXELS) begin
            set_pace();
            case ($urandom_range(0, 9))
                0: ;
                1: configure($urandom_range(0, 1) ? CFG_SPARE_LO : CFG_SPARE_HI,
                             CFG_DATA_W'($urandom_range(0, 8191)));
                default: begin
                    w = pick_dim();
                    h = pick_dim();
                    if (eff_dim(w) * eff_dim(h) > 160) h = 13'd2;
                    configure(CFG_SOURCE_WIDTH, w);
                    configure(CFG_SOURCE_HEIGHT, h);
                end
            endcase
            count = eff_dim(model_width) * eff_dim(model_height);
            if ($urandom_range(0, 6) == 0 && count > 1)
                count = $urandom_range(1, count - 1);
            send_texels(count);
            sent += count;
        end

        wait_quiet();
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Run limit, several times the slowest correct run.
    initial begin
        #(12 * 400000);
        $display("end of test: mismatches");
        $finish;
    end

endmodule
